[hdl/lmdb_pkg.sv]
package lmdb_pkg;

    typedef enum logic [2:0] {
        K_WRITE_ROW = 3'd0,
        K_OR_ROW    = 3'd1,
        K_SET_PIXEL = 3'd2,
        K_LINE      = 3'd3,
        K_CLEAR     = 3'd4,
        K_PRESENT   = 3'd5,
        K_TICK      = 3'd6,
        K_NONE      = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  row;
        logic [5:0]  column;
        logic [5:0]  end_row;
        logic [5:0]  end_column;
        logic [15:0] row_data;
    } t_cmd;

    localparam logic [15:0] BLANK_WORD = 16'hFFFF;
    localparam logic [15:0] MSB_WORD   = 16'b1000000000000000;
    localparam int          QUEUE_DEPTH = 2;

endpackage

[hdl/lmdb_front.sv]
module lmdb_front
    import lmdb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_column,
    input  logic [5:0]  i_end_row,
    input  logic [5:0]  i_end_column,
    input  logic [15:0] i_row_data,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_cmd       r_queue [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_in;

    always_comb begin
        w_in.kind       = t_kind'(i_kind);
        w_in.row        = i_row;
        w_in.column     = i_column;
        w_in.end_row    = i_end_row;
        w_in.end_column = i_end_column;
        w_in.row_data   = i_row_data;
    end

    assign o_ready     = (r_count != 2'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];
    // unused kind is dropped here
    assign w_push      = i_valid && o_ready && (w_in.kind != K_NONE);
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_queue[r_wr_ptr] <= w_in;
                r_wr_ptr          <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'(QUEUE_DEPTH)) |-> !o_ready) else $error("ready while full");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !o_cmd_valid) else $error("pop from empty queue");
`endif

endmodule

[hdl/lmdb_back.sv]
module lmdb_back
    import lmdb_pkg::*;
#(
    parameter int ROWS    = 10,
    parameter int COLUMNS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_column_bits,
    output logic [15:0] o_row_select,
    output logic        o_is_data_frame,
    output logic        o_last
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RMW, S_LINE, S_SWEEP, S_TICK_RD, S_OUT_BLANK, S_OUT_DATA
    } t_state;

    t_state       r_state;
    logic [15:0]  r_store [2][ROWS];
    logic         r_valid [2][ROWS];
    logic         r_shown;
    logic         r_draw;
    logic         r_swap;
    logic [RW-1:0] r_scan;
    logic [RW-1:0] r_idx;
    t_cmd         r_cmd;
    logic signed [6:0] r_x;
    logic signed [6:0] r_y;
    logic signed [8:0] r_err;
    logic signed [6:0] r_dx;
    logic signed [6:0] r_dy;
    logic         r_sweep_inv;
    logic [15:0]  r_word;
    logic [15:0]  r_sel;
    logic         r_out_valid;
    logic [15:0]  r_col_bits;
    logic         r_is_data;
    logic         r_last;

    logic signed [6:0] w_x1;
    logic signed [6:0] w_y1;
    logic signed [9:0] w_e2;
    logic         w_pix_ok;
    logic [RW-1:0] w_pix_row;
    logic [15:0]  w_pix_mask;
    logic [15:0]  w_draw_word;
    logic [15:0]  w_idx_word;
    logic         w_row_ok;
    logic [RW-1:0] w_cmd_row;
    logic [15:0]  w_cmd_word;
    logic [15:0]  w_shown_word;

    assign o_cmd_ready     = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_column_bits   = r_col_bits;
    assign o_row_select    = r_sel;
    assign o_is_data_frame = r_is_data;
    assign o_last          = r_last;

    assign w_x1 = 7'(signed'(r_cmd.end_column));
    assign w_y1 = 7'(signed'(r_cmd.end_row));
    assign w_e2 = 10'(r_err) <<< 1;

    assign w_pix_ok   = (r_x >= 0) && (r_y >= 0) && (r_x < 7'(COLUMNS)) && (r_y < 7'(ROWS))
                        && (r_x <= 7'sd15);
    assign w_pix_row  = RW'(r_y[5:0]);
    assign w_pix_mask = MSB_WORD >> r_x[3:0];
    assign w_draw_word = r_valid[r_draw][w_pix_row] ? r_store[r_draw][w_pix_row] : 16'd0;
    assign w_idx_word  = r_valid[r_draw][r_idx] ? r_store[r_draw][r_idx] : 16'd0;

    assign w_row_ok   = !r_cmd.row[5] && (r_cmd.row < 6'(ROWS));
    assign w_cmd_row  = RW'(r_cmd.row);
    assign w_cmd_word = r_valid[r_draw][w_cmd_row] ? r_store[r_draw][w_cmd_row] : 16'd0;
    assign w_shown_word = r_valid[r_shown][r_scan] ? r_store[r_shown][r_scan] : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shown     <= 1'b0;
            r_draw      <= 1'b0;
            r_swap      <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < 2; p++) begin
                for (int r = 0; r < ROWS; r++) begin
                    r_valid[p][r] <= 1'b0;
                end
            end
        end else begin
            if (r_out_valid && i_ready && (r_state != S_OUT_BLANK)
                && (r_state != S_OUT_DATA)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_x   <= 7'(signed'(i_cmd.column));
                        r_y   <= 7'(signed'(i_cmd.row));
                        r_idx <= '0;
                        case (i_cmd.kind)
                            K_WRITE_ROW, K_OR_ROW, K_SET_PIXEL: r_state <= S_RMW;
                            K_LINE:    r_state <= S_LINE;
                            K_CLEAR: begin
                                r_draw      <= ~r_shown;
                                r_sweep_inv <= 1'b0;
                                r_state     <= S_SWEEP;
                            end
                            K_PRESENT: begin
                                r_sweep_inv <= 1'b1;
                                r_swap      <= 1'b1;
                                r_state     <= S_SWEEP;
                            end
                            K_TICK: begin
                                if (r_swap) begin
                                    r_shown <= ~r_shown;
                                    r_swap  <= 1'b0;
                                end
                                r_state <= S_TICK_RD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                        begin
                            logic signed [6:0] dxa;
                            logic signed [6:0] dya;
                            dxa = 7'(signed'(i_cmd.end_column)) - 7'(signed'(i_cmd.column));
                            dya = 7'(signed'(i_cmd.end_row)) - 7'(signed'(i_cmd.row));
                            if (dxa < 0) dxa = -dxa;
                            if (dya < 0) dya = -dya;
                            r_dx  <= dxa;
                            r_dy  <= -dya;
                            r_err <= 9'(dxa) - 9'(dya);
                        end
                    end
                end
                S_RMW: begin
                    if (r_cmd.kind == K_SET_PIXEL) begin
                        if (w_pix_ok) begin
                            r_store[r_draw][w_pix_row] <= w_draw_word | w_pix_mask;
                            r_valid[r_draw][w_pix_row] <= 1'b1;
                        end
                    end else if (w_row_ok) begin
                        r_store[r_draw][w_cmd_row] <= (r_cmd.kind == K_OR_ROW)
                            ? (w_cmd_word | r_cmd.row_data) : r_cmd.row_data;
                        r_valid[r_draw][w_cmd_row] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_LINE: begin
                    // one bresenham point per cycle
                    logic signed [8:0] ne;
                    if (w_pix_ok) begin
                        r_store[r_draw][w_pix_row] <= w_draw_word | w_pix_mask;
                        r_valid[r_draw][w_pix_row] <= 1'b1;
                    end
                    if (r_x == w_x1 && r_y == w_y1) begin
                        r_state <= S_IDLE;
                    end else begin
                        ne = r_err;
                        if (w_e2 >= 10'(r_dy)) begin
                            ne  = ne + 9'(r_dy);
                            r_x <= (r_x < w_x1) ? r_x + 7'sd1 : r_x - 7'sd1;
                        end
                        if (w_e2 <= 10'(r_dx)) begin
                            ne  = ne + 9'(r_dx);
                            r_y <= (r_y < w_y1) ? r_y + 7'sd1 : r_y - 7'sd1;
                        end
                        r_err <= ne;
                    end
                end
                S_SWEEP: begin
                    r_store[r_draw][r_idx] <= r_sweep_inv ? ~w_idx_word : 16'd0;
                    r_valid[r_draw][r_idx] <= 1'b1;
                    if (r_idx == RW'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + RW'(1);
                    end
                end
                S_TICK_RD: begin
                    // row select is on the output, so wait until the held beat leaves
                    if (!r_out_valid || i_ready) begin
                        r_word  <= w_shown_word;
                        r_sel   <= 16'(17'd1 << r_scan);
                        r_scan  <= (r_scan == RW'(ROWS - 1)) ? '0 : r_scan + RW'(1);
                        r_state <= S_OUT_BLANK;
                    end
                end
                S_OUT_BLANK: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_col_bits  <= BLANK_WORD;
                        r_is_data   <= 1'b0;
                        r_last      <= 1'b0;
                        r_state     <= S_OUT_DATA;
                    end
                end
                S_OUT_DATA: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_col_bits  <= r_word;
                        r_is_data   <= 1'b1;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_scan) < ROWS) else $error("scan row out of range");
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_sel)) else $error("row select not one-hot");
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_is_data == r_last)) else $error("frame marks disagree");
`endif

endmodule

[hdl/led_matrix_double_buffer_scan.sv]
// Two-page 16-bit-row LED frame store with row-multiplexed scan. Commands pass through a
// two-entry queue into an executor that handles one command at a time: row writes and pixel
// sets go through a single update state, a line draw plots one Bresenham point per cycle, clear
// and present sweep every row of the draw page, and a scan tick offers both frames (blanking,
// then data with last set) on the output register, waiting on the receiver's ready for each.
module led_matrix_double_buffer_scan
    import lmdb_pkg::*;
#(
    parameter int ROWS    = 10,
    parameter int COLUMNS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_column,
    input  logic [5:0]  i_end_row,
    input  logic [5:0]  i_end_column,
    input  logic [15:0] i_row_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_column_bits,
    output logic [15:0] o_row_select,
    output logic        o_is_data_frame,
    output logic        o_last
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    lmdb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_end_row    (i_end_row),
        .i_end_column (i_end_column),
        .i_row_data   (i_row_data),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    lmdb_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_ready     (w_cmd_ready),
        .i_cmd           (w_cmd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_column_bits   (o_column_bits),
        .o_row_select    (o_row_select),
        .o_is_data_frame (o_is_data_frame),
        .o_last          (o_last)
    );

endmodule

[verif/tb_led_matrix_double_buffer_scan.sv]
`timescale 1ns / 1ps

module tb_led_matrix_double_buffer_scan;
    import lmdb_pkg::*;

    localparam int ROWS     = 10;
    localparam int COLUMNS  = 11;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [15:0] column_bits;
        logic [15:0] row_select;
        logic        is_data_frame;
        logic        last;
    } t_frame;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [5:0]  i_row;
    logic [5:0]  i_column;
    logic [5:0]  i_end_row;
    logic [5:0]  i_end_column;
    logic [15:0] i_row_data;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_column_bits;
    logic [15:0] o_row_select;
    logic        o_is_data_frame;
    logic        o_last;

    // predictor state
    logic [15:0] pages [2][ROWS];
    logic        shown_pg;
    logic        draw_pg;
    logic        swap_req;
    int          scan_idx;

    t_frame frames_due[$];
    int     mismatches;
    int     frames_seen;
    int     beats_sent;
    int     idle_cycles;
    bit     rx_stall_off;

    led_matrix_double_buffer_scan #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h (frame %0d)", what, got, want, frames_seen);
    endtask

    function automatic void plot(input int x, input int y);
        if (x >= 0 && y >= 0 && x < COLUMNS && y < ROWS && x <= 15)
            pages[draw_pg][y] |= MSB_WORD >> x;
    endfunction

    function automatic void trace_line(input int x0, input int y0, input int x1, input int y1);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy  = (y1 > y0) ? y0 - y1 : y1 - y0;
        sx  = (x0 < x1) ? 1 : -1;
        sy  = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        for (int g = 0; g < 256; g++) begin
            plot(x0, y0);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x0  += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y0  += sy;
            end
        end
    endfunction

    function automatic void apply_command(input t_cmd c);
        int r;
        int x;
        t_frame f;
        r = $signed(c.row);
        x = $signed(c.column);
        case (c.kind)
            K_WRITE_ROW: if (r >= 0 && r < ROWS) pages[draw_pg][r] = c.row_data;
            K_OR_ROW:    if (r >= 0 && r < ROWS) pages[draw_pg][r] |= c.row_data;
            K_SET_PIXEL: plot(x, r);
            K_LINE:      trace_line(x, r, $signed(c.end_column), $signed(c.end_row));
            K_CLEAR: begin
                draw_pg = ~shown_pg;
                for (int i = 0; i < ROWS; i++) pages[draw_pg][i] = '0;
            end
            K_PRESENT: begin
                for (int i = 0; i < ROWS; i++) pages[draw_pg][i] = ~pages[draw_pg][i];
                swap_req = 1'b1;
            end
            K_TICK: begin
                if (swap_req) begin
                    shown_pg = ~shown_pg;
                    swap_req = 1'b0;
                end
                f.column_bits   = BLANK_WORD;
                f.row_select    = 16'(1 << scan_idx);
                f.is_data_frame = 1'b0;
                f.last          = 1'b0;
                frames_due.push_back(f);
                f.column_bits   = pages[shown_pg][scan_idx];
                f.is_data_frame = 1'b1;
                f.last          = 1'b1;
                frames_due.push_back(f);
                scan_idx = (scan_idx + 1 >= ROWS) ? 0 : scan_idx + 1;
            end
            default: ;
        endcase
    endfunction

    task automatic send_beat(input t_cmd c, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= c.kind;
        i_row        <= c.row;
        i_column     <= c.column;
        i_end_row    <= c.end_row;
        i_end_column <= c.end_column;
        i_row_data   <= c.row_data;
        do @(posedge i_clk); while (!o_ready);
        apply_command(c);
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_cmd make_cmd(input t_kind k, input int r, input int x,
                                      input int er, input int ex, input logic [15:0] d);
        t_cmd c;
        c.kind       = k;
        c.row        = 6'(r);
        c.column     = 6'(x);
        c.end_row    = 6'(er);
        c.end_column = 6'(ex);
        c.row_data   = d;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   sel;
        c   = t_cmd'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            // mostly in-range coordinates
            c.row        = 6'($urandom_range(0, ROWS));
            c.column     = 6'($urandom_range(0, COLUMNS));
            c.end_row    = 6'($urandom_range(0, ROWS));
            c.end_column = 6'($urandom_range(0, COLUMNS));
        end
        sel = $urandom_range(0, 99);
        if (sel < 30)      c.kind = K_TICK;
        else if (sel < 38) c.kind = K_CLEAR;
        else if (sel < 44) c.kind = K_PRESENT;
        else if (sel < 47) c.kind = K_NONE;
        else               c.kind = t_kind'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic test_directed();
        send_beat(make_cmd(K_TICK, 0, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_WRITE_ROW, 0, 0, 0, 0, 16'hFFFF), 0);
        send_beat(make_cmd(K_WRITE_ROW, ROWS - 1, 0, 0, 0, 16'hA5A5), 0);
        send_beat(make_cmd(K_WRITE_ROW, ROWS, 0, 0, 0, 16'h1234), 0);
        send_beat(make_cmd(K_WRITE_ROW, -1, 0, 0, 0, 16'h4321), 0);
        send_beat(make_cmd(K_OR_ROW, 1, 0, 0, 0, 16'h5A5A), 0);
        send_beat(make_cmd(K_SET_PIXEL, 2, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_SET_PIXEL, 2, COLUMNS - 1, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_SET_PIXEL, 2, COLUMNS, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_SET_PIXEL, 3, -32, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_LINE, 0, 0, ROWS - 1, COLUMNS - 1, 16'h0), 0);
        send_beat(make_cmd(K_LINE, -32, 31, 31, -32, 16'h0), 0);
        send_beat(make_cmd(K_LINE, 5, 5, 5, 5, 16'h0), 0);
        send_beat(make_cmd(K_NONE, 1, 1, 1, 1, 16'hFFFF), 0);
        for (int i = 0; i < 3; i++) send_beat(make_cmd(K_TICK, 0, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_PRESENT, 0, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_TICK, 0, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_CLEAR, 0, 0, 0, 0, 16'h0), 0);
        send_beat(make_cmd(K_WRITE_ROW, 3, 0, 0, 0, 16'h8001), 0);
        send_beat(make_cmd(K_PRESENT, 0, 0, 0, 0, 16'h0), 0);
        for (int i = 0; i < ROWS + 1; i++) send_beat(make_cmd(K_TICK, 0, 0, 0, 0, 16'h0), 1);
    endtask

    task automatic test_random();
        for (int i = 0; i < 780; i++) begin
            rx_stall_off = (i / 100) % 3 == 2;
            send_beat(random_cmd(), rx_stall_off);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_valid && i_ready) begin
            frames_seen++;
            if (frames_due.size() == 0) begin
                mismatches++;
                $display("mismatch: unexpected frame %0d", frames_seen);
            end else begin
                want = frames_due.pop_front();
                if (o_column_bits !== want.column_bits)
                    report("column_bits", o_column_bits, want.column_bits);
                if (o_row_select !== want.row_select)
                    report("row_select", o_row_select, want.row_select);
                if (o_is_data_frame !== want.is_data_frame)
                    report("is_data_frame", 16'(o_is_data_frame), 16'(want.is_data_frame));
                if (o_last !== want.last)
                    report("last", 16'(o_last), 16'(want.last));
            end
        end
    end

    // receiver stall
    initial begin
        int wait_n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            wait_n = rx_stall_off ? 0 : $urandom_range(0, 7);
            if (wait_n > 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout with %0d frames outstanding", frames_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches   = 0;
        frames_seen  = 0;
        beats_sent   = 0;
        idle_cycles  = 0;
        rx_stall_off = 1'b0;
        shown_pg     = 1'b0;
        draw_pg      = 1'b0;
        swap_req     = 1'b0;
        scan_idx     = 0;
        for (int p = 0; p < 2; p++)
            for (int i = 0; i < ROWS; i++) pages[p][i] = '0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = K_NONE;
        i_row        = '0;
        i_column     = '0;
        i_end_row    = '0;
        i_end_column = '0;
        i_row_data   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();
        i_valid <= 1'b0;

        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("sent %0d commands, checked %0d scan frames", beats_sent, frames_seen);
        $display("covered row writes, pixels, lines, clear, present and page swaps");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
